@@ sv/wrpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wrpm_pkg;

  localparam int MAX_WINDOW  = 8192;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int WIN_W       = 14;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W       = 61;
  localparam int CNT_W       = 31;
  localparam int MS_W        = 31;
  localparam int PEAK_W      = 16;
  localparam int FRAME_W     = 30;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = WIN_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [WIN_W-1:0]     WINDOW_RESET = WIN_W'(5760);
  localparam logic [CNT_W-1:0]     COUNT_MAX    = {CNT_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE  = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQNEW,
    S_ADD,
    S_SUB,
    S_MAX,
    S_DIVA_GO,
    S_DIVA_WAIT,
    S_DIVW_GO,
    S_DIVW_WAIT,
    S_DONE
  } meter_state_e;

  typedef struct packed {
    logic                          we;
    logic [PTR_W-1:0]              waddr;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic                          re;
    logic [PTR_W-1:0]              raddr;
  } ring_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ sv/wrpm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wrpm_in_if import wrpm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] probe_sample;
  logic signed [SAMPLE_BITS-1:0] baseline_sample;
  logic                          probe_present;
  logic                          last_sample;

  modport source (
    output valid, probe_sample, baseline_sample, probe_present, last_sample,
    input  ready
  );

  modport sink (
    input  valid, probe_sample, baseline_sample, probe_present, last_sample,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/wrpm_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wrpm_out_if import wrpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MS_W-1:0]    mean_square_all;
  logic [MS_W-1:0]    window_mean_square_max;
  logic [PEAK_W-1:0]  peak_magnitude;
  logic [FRAME_W-1:0] frame_count;

  modport source (
    output valid, mean_square_all, window_mean_square_max, peak_magnitude, frame_count,
    input  ready
  );

  modport sink (
    input  valid, mean_square_all, window_mean_square_max, peak_magnitude, frame_count,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/windowed_rms_peak_meter.sv @@
// Ordinary word: accepted in S_IDLE, then worked through S_SQNEW, S_ADD, S_SUB and
//   S_MAX with the shared squarer; the next word is taken only back in S_IDLE.
// Last word: after S_MAX two 61-step divides run back to back on the shared divider,
//   then the result is loaded in S_DONE and the next word is taken back in S_IDLE.
// Reset clears control, pointer, sums, peak and count; the sample ring is not
//   cleared, as an entry is read only after it was written in this measurement.
`timescale 1ns / 1ps
`default_nettype none

module windowed_rms_peak_meter import wrpm_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  wrpm_in_if.sink              in_i,
  wrpm_out_if.source           out_o
);

  meter_state_e state_q, state_d;

  logic [WIN_W-1:0]              window_len_q;
  logic                          diff_mode_q;
  logic signed [SAMPLE_BITS-1:0] v_q;
  logic                          last_q;
  logic                          drop_en_q;
  logic [SQ_W-1:0]               sq_q;
  logic [PTR_W-1:0]              ptr_q;
  logic [SUM_W-1:0]              total_q;
  logic [SUM_W-1:0]              ws_q;
  logic [SUM_W-1:0]              wmax_q;
  logic [PEAK_W-1:0]             peak_q;
  logic [CNT_W-1:0]              count_q;
  logic [MS_W-1:0]               msa_q;
  logic [MS_W-1:0]               msw_q;

  logic               out_valid_q;
  logic [MS_W-1:0]    out_msa_q;
  logic [MS_W-1:0]    out_msw_q;
  logic [PEAK_W-1:0]  out_peak_q;
  logic [FRAME_W-1:0] out_frame_q;

  logic                          in_fire;
  logic                          out_load;
  logic [WIN_W-1:0]              w_eff;
  logic [CNT_W-1:0]              div_w;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS-1:0] v_new;
  logic [PEAK_W-1:0]             mag;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [2*SAMPLE_BITS-1:0] mul_p;
  logic [SUM_W:0]                total_add;
  logic [SUM_W:0]                ws_add;
  logic [SUM_W-1:0]              sq_ext;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  ring_req_t                     ring_req;
  logic                          div_start;
  logic [SUM_W-1:0]              div_dvd;
  logic [CNT_W-1:0]              div_dsr;
  div_stat_t                     div_stat;
  logic [MS_W-1:0]               div_quo;

  // effective window and divisor
  always_comb begin
    if (window_len_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_len_q > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = window_len_q;
    end
    div_w = ({{(CNT_W-WIN_W){1'b0}}, w_eff} < count_q) ?
            {{(CNT_W-WIN_W){1'b0}}, w_eff} : count_q;
  end

  // measured value
  always_comb begin
    diff = {in_i.probe_sample[SAMPLE_BITS-1], in_i.probe_sample}
         - {in_i.baseline_sample[SAMPLE_BITS-1], in_i.baseline_sample};
    if (!diff_mode_q) begin
      v_new = in_i.probe_sample;
    end else if (!in_i.probe_present) begin
      v_new = '0;
    end else if (diff[SAMPLE_BITS] != diff[SAMPLE_BITS-1]) begin
      v_new = diff[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      v_new = diff[SAMPLE_BITS-1:0];
    end
  end

  // shared squarer
  assign mul_a  = (state_q == S_SQNEW) ? v_q : rd_data;
  assign mul_p  = mul_a * mul_a;
  assign sq_ext = {{(SUM_W-SQ_W){1'b0}}, sq_q};

  assign total_add = {1'b0, total_q} + {1'b0, sq_ext};
  assign ws_add    = {1'b0, ws_q} + {1'b0, sq_ext};
  assign mag       = v_q[SAMPLE_BITS-1] ? PEAK_W'(-{v_q[SAMPLE_BITS-1], v_q})
                                        : PEAK_W'(v_q);

  assign in_fire = in_i.valid && in_i.ready;

  // sequencer
  always_comb begin
    state_d        = state_q;
    in_i.ready     = 1'b0;
    out_load       = 1'b0;
    div_start      = 1'b0;
    div_dvd        = total_q;
    div_dsr        = count_q;
    ring_req.we    = 1'b0;
    ring_req.waddr = ptr_q;
    ring_req.wdata = v_q;
    ring_req.re    = 1'b0;
    ring_req.raddr = ptr_q - w_eff[PTR_W-1:0];
    case (state_q)
      S_IDLE: begin
        in_i.ready  = 1'b1;
        ring_req.re = 1'b1;
        if (in_i.valid) begin
          state_d = S_SQNEW;
        end
      end
      S_SQNEW: begin
        ring_req.we = 1'b1;
        state_d     = S_ADD;
      end
      S_ADD: state_d = S_SUB;
      S_SUB: state_d = S_MAX;
      S_MAX: state_d = last_q ? S_DIVA_GO : S_IDLE;
      S_DIVA_GO: begin
        div_start = 1'b1;
        state_d   = S_DIVA_WAIT;
      end
      S_DIVA_WAIT: begin
        if (div_stat.done) begin
          state_d = S_DIVW_GO;
        end
      end
      S_DIVW_GO: begin
        div_start = 1'b1;
        div_dvd   = wmax_q;
        div_dsr   = div_w;
        state_d   = S_DIVW_WAIT;
      end
      S_DIVW_WAIT: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_RESET;
      diff_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_LEN: window_len_q <= cfg_data_i;
        REG_DIFF_MODE:  diff_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      total_q <= '0;
      ws_q    <= '0;
      wmax_q  <= '0;
      peak_q  <= '0;
      count_q <= '0;
    end else begin
      case (state_q)
        S_SQNEW: ptr_q <= ptr_q + PTR_W'(1);
        S_ADD: begin
          total_q <= total_add[SUM_W] ? {SUM_W{1'b1}} : total_add[SUM_W-1:0];
          ws_q    <= ws_add[SUM_W] ? {SUM_W{1'b1}} : ws_add[SUM_W-1:0];
          if (mag > peak_q) begin
            peak_q <= mag;
          end
          if (count_q != COUNT_MAX) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        S_SUB: ws_q <= (ws_q > sq_ext) ? ws_q - sq_ext : '0;
        S_MAX: begin
          if (ws_q > wmax_q) begin
            wmax_q <= ws_q;
          end
        end
        S_DONE: begin
          if (out_load) begin
            ptr_q   <= '0;
            total_q <= '0;
            ws_q    <= '0;
            wmax_q  <= '0;
            peak_q  <= '0;
            count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-word payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q       <= v_new;
      last_q    <= in_i.last_sample;
      drop_en_q <= count_q >= {{(CNT_W-WIN_W){1'b0}}, w_eff};
    end
    if (state_q == S_SQNEW) begin
      sq_q <= mul_p[SQ_W-1:0];
    end
    if (state_q == S_ADD) begin
      sq_q <= drop_en_q ? mul_p[SQ_W-1:0] : '0;
    end
    if (state_q == S_DIVA_WAIT && div_stat.done) begin
      msa_q <= div_quo;
    end
    if (state_q == S_DIVW_WAIT && div_stat.done) begin
      msw_q <= div_quo;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_msa_q   <= msa_q;
      out_msw_q   <= msw_q;
      out_peak_q  <= peak_q;
      out_frame_q <= count_q[CNT_W-1:1];
    end
  end

  assign out_o.valid                  = out_valid_q;
  assign out_o.mean_square_all        = out_msa_q;
  assign out_o.window_mean_square_max = out_msw_q;
  assign out_o.peak_magnitude         = out_peak_q;
  assign out_o.frame_count            = out_frame_q;

  wrpm_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (rd_data)
  );

  wrpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIVA_WAIT || state_q == S_DIVW_WAIT))
    else $error("divider finished outside a wait state");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQNEW) |=> (ptr_q == $past(ptr_q) + PTR_W'(1)))
    else $error("ring pointer did not advance after write");

  a_clear_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (count_q == '0 && ptr_q == '0 && wmax_q == '0 && out_o.valid))
    else $error("measurement not cleared when result loaded");

endmodule

`default_nettype wire

@@ sv/wrpm_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wrpm_ring import wrpm_pkg::*; (
  input  wire                           clk_i,
  input  ring_req_t                     req_i,
  output logic signed [SAMPLE_BITS-1:0] rdata_o
);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/wrpm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit a cycle; low MS_W quotient bits kept
module wrpm_div import wrpm_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire [SUM_W-1:0]   dividend_i,
  input  wire [CNT_W-1:0]   divisor_i,
  output div_stat_t         stat_o,
  output logic [MS_W-1:0]   quotient_o
);

  logic [SUM_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]     dsr_q, dsr_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [MS_W-1:0]      quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;

  always_comb begin
    trial  = {rem_q, dvd_q[SUM_W-1]};
    diff   = trial - {1'b0, dsr_q};
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[MS_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[MS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire
